/* src/aars_pkg.sv */
// Package with types, decode codes and helpers for the address reference scanner.
package aars_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned RegIdxW  = $clog2(RegCount);

  localparam logic [1:0] CfgTarget     = 2'd0;
  localparam logic [1:0] CfgOccurrence = 2'd1;
  localparam logic [1:0] CfgImageBase  = 2'd2;

  typedef enum logic [2:0] {
    OpNone,
    OpAdrp,
    OpAddImm,
    OpLdrUoff,
    OpAdr,
    OpLdrLit,
    OpSkip
  } op_e;

  // Classified beat passed from the front end to the back end.
  typedef struct packed {
    op_e                  op;
    logic [RegIdxW-1:0]   rd;
    logic [RegIdxW-1:0]   rn;
    logic [63:0]          imm;     // value added to the base (rn or offset)
    logic [31:0]          off;     // aligned offset
    logic                 start;
    logic                 last;
  } dec_t;

  typedef struct packed {
    logic        found;
    logic [63:0] ref_address;
  } res_t;

endpackage

/* src/aars_if.sv */
// Valid/ready channel interfaces for instruction and result beats.
interface aars_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] instr_offset;
  logic        scan_start;
  logic        scan_last;
  modport source (output valid, instr_word, instr_offset, scan_start, scan_last, input ready);
  modport sink (input valid, instr_word, instr_offset, scan_start, scan_last, output ready);
endinterface

interface aars_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] ref_address;
  modport source (output valid, found, ref_address, input ready);
  modport sink (input valid, found, ref_address, output ready);
endinterface

/* src/aars_front.sv */
// Front end: accepts instruction beats, decodes them and pushes them into a queue.
module aars_front
  import aars_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  aars_in_if.sink  in_if,
  output logic     q_valid_o,
  output dec_t     q_data_o,
  input  logic     q_pop_i
);

  localparam int unsigned Depth = 2;

  dec_t        fifo_q [Depth];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  dec_t        dec;
  logic [31:0] w;
  logic [63:0] adr_imm;
  logic        push;

  assign w = in_if.instr_word;
  assign adr_imm = {{43{w[23]}}, w[23:5], w[30:29]};

  always_comb begin
    dec       = '0;
    dec.rd    = w[4:0];
    dec.rn    = w[9:5];
    dec.off   = {in_if.instr_offset[31:2], 2'b00};
    dec.start = in_if.scan_start;
    dec.last  = in_if.scan_last;
    dec.op    = OpNone;
    dec.imm   = '0;
    if ((w & 32'h9F00_0000) == 32'h9000_0000) begin
      dec.op  = OpAdrp;
      dec.imm = {adr_imm[51:0], 12'h000};
    end else if ((w & 32'hFF00_0000) == 32'h9100_0000) begin
      if (w[23]) begin
        dec.op = OpSkip;
      end else begin
        dec.op  = OpAddImm;
        dec.imm = w[22] ? {40'd0, w[21:10], 12'h000} : {52'd0, w[21:10]};
      end
    end else if ((w & 32'hF9C0_0000) == 32'hF940_0000) begin
      if (w[21:10] == 12'd0) begin
        dec.op = OpSkip;
      end else begin
        dec.op  = OpLdrUoff;
        dec.imm = {49'd0, w[21:10], 3'b000};
      end
    end else if ((w & 32'h9F00_0000) == 32'h1000_0000) begin
      dec.op  = OpAdr;
      dec.imm = adr_imm;
    end else if ((w & 32'hFF00_0000) == 32'h5800_0000) begin
      dec.op  = OpLdrLit;
      dec.imm = {43'd0, w[23:5], 2'b00};
    end
  end

  assign in_if.ready = (cnt_q != 2'(Depth));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(Depth) |-> !in_if.ready) else $error("ready while full");
`endif

endmodule

/* src/aars_back.sv */
// Back end: tracked register file update, target compare, match count and result register.
module aars_back
  import aars_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  dec_t        q_data_i,
  output logic        q_pop_o,
  input  logic [63:0] target_i,
  input  logic [15:0] occurrence_i,
  input  logic [63:0] image_base_i,
  aars_out_if.source  out_if
);

  logic [63:0]  regs_q [RegCount];
  logic [RegCount-1:0] vld_q;   // cleared entries read as zero
  logic [RegCount-1:0] vld_d;
  logic [15:0]  count_q, count_d;
  logic         done_q, done_d;
  logic         out_valid_q, out_valid_d;
  res_t         res_q;

  dec_t         d;
  logic         done_eff;
  logic [63:0]  rn_val, rd_old, base, new_val, rd_val, what;
  logic         writes, compare, hit, matched;
  logic [15:0]  count_eff;

  assign d = q_data_i;
  // Output register may be refilled when empty or drained this cycle.
  assign q_pop_o = q_valid_i && (!out_valid_q || out_if.ready);

  always_comb begin
    done_eff  = d.start ? 1'b0 : done_q;
    count_eff = d.start ? 16'd1 : count_q;
    rn_val    = (!d.start && vld_q[d.rn]) ? regs_q[d.rn] : 64'd0;
    rd_old    = (!d.start && vld_q[d.rd]) ? regs_q[d.rd] : 64'd0;
    writes    = 1'b1;
    compare   = 1'b1;
    case (d.op)
      OpAdrp:                base = {32'd0, d.off[31:12], 12'h000};
      OpAddImm, OpLdrUoff:   base = rn_val;
      OpAdr, OpLdrLit:       base = {32'd0, d.off};
      OpSkip: begin
        base    = 64'd0;
        writes  = 1'b0;
        compare = 1'b0;
      end
      default: begin
        base   = 64'd0;
        writes = 1'b0;
      end
    endcase
    new_val = base + d.imm;
    rd_val  = writes ? new_val : rd_old;
    what    = ((target_i & image_base_i) != 64'd0) ? target_i - image_base_i : target_i;
    matched = compare && (rd_val == what);
    hit     = matched && (count_eff == occurrence_i);
  end

  // Next state of the scan bookkeeping and the result valid flag.
  always_comb begin
    vld_d       = vld_q;
    count_d     = count_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_if.ready;
    if (q_pop_o) begin
      if (d.start) begin
        vld_d   = '0;
        count_d = 16'd1;
        done_d  = 1'b0;
      end
      if (!done_eff) begin
        if (writes) begin
          vld_d[d.rd] = 1'b1;
        end
        if (matched && !hit && count_eff != 16'hFFFF) begin
          count_d = count_eff + 16'd1;
        end
        if (hit || d.last) begin
          done_d      = 1'b1;
          out_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && !done_eff && writes) begin
      regs_q[d.rd] <= new_val;
    end
    if (q_pop_o && !done_eff && (hit || d.last)) begin
      res_q.found       <= hit;
      res_q.ref_address <= {32'd0, d.off} + (hit ? 64'd0 : 64'd4) + image_base_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      count_q     <= 16'd1;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      count_q     <= count_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.found       = res_q.found;
  assign out_if.ref_address = res_q.ref_address;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(res_q))
    else $error("result lost under stall");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> done_q) else $error("result without done");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 16'd0) else $error("match count wrapped");
`endif

endmodule

/* src/arm64_address_reference_scan.sv */
// Top level of the AArch64 address reference scanner.
//
// Instruction beats enter on in_if (word, file offset, scan start and last
// flags); result beats leave on out_if (found flag and reference address).
// Configuration registers (target address, occurrence, image base) are
// written through cfg_we_i / cfg_idx_i / cfg_data_i only while the block is
// idle; the user must keep to this, as the block does not enforce it. The
// front end decodes each beat in the cycle it is accepted and places it in a
// two-entry queue. The back end reads the tracked register file, adds the
// immediate, compares with the base-adjusted target and writes back, so one
// beat is retired per cycle while the output register is empty or drained.
// A stalled output holds its result register; the back end then stops and
// the queue fills, after which in_if.ready drops. Reset empties the queue,
// clears the tracked registers through per-entry valid bits, sets the match
// count to one and restores the configuration reset values.
module arm64_address_reference_scan
  import aars_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  aars_in_if.sink     in_if,
  aars_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] target_q, image_base_q;
  logic [15:0] occurrence_q;
  logic        q_valid, q_pop;
  dec_t        q_data;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= 64'd0;
      occurrence_q <= 16'd1;
      image_base_q <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTarget:     target_q     <= cfg_data_i;
        CfgOccurrence: occurrence_q <= cfg_data_i[15:0];
        CfgImageBase:  image_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aars_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  aars_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .target_i     (target_q),
    .occurrence_i (occurrence_q),
    .image_base_i (image_base_q),
    .out_if       (out_if)
  );

endmodule
